### sv/fnvfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvfm_pkg
// shared types and constants for the fnv-1a / fmix64 worker router
// ----------------------------------------------------------------------------
package fnvfm_pkg;

    // field widths
    localparam int HASH_W   = 64;
    localparam int HALF_W   = HASH_W / 2;
    localparam int BYTE_W   = 8;
    localparam int WCNT_W   = 7;
    localparam int IDX_W    = 6;
    localparam int BITCNT_W = $clog2(HASH_W);

    // fnv-1a 64-bit constants; prime is 2^40 + 2^8 + 0xb3
    localparam logic [HASH_W-1:0] FNV_BASIS   = 64'hcbf2_9ce4_8422_2325;
    localparam logic [7:0]        FNV_PRIME_LO = 8'hb3;
    localparam int                FNV_SH_MID  = 8;
    localparam int                FNV_SH_HI   = 40;

    // fmix64 constants
    localparam logic [HASH_W-1:0] FMIX_C1    = 64'hff51_afd7_ed55_8ccd;
    localparam logic [HASH_W-1:0] FMIX_C2    = 64'hc4ce_b9fe_1a85_ec53;
    localparam int                FMIX_SHIFT = 33;

    // source of the shift-xor step
    localparam logic [1:0] Z_NONE      = 2'd0;
    localparam logic [1:0] Z_FROM_HASH = 2'd1;
    localparam logic [1:0] Z_FROM_ACC  = 2'd2;

    // accumulator operation for the split multiply
    localparam logic [1:0] ACC_NONE   = 2'd0;
    localparam logic [1:0] ACC_LOAD   = 2'd1;
    localparam logic [1:0] ACC_ADD_HI = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       fnv_fin;
        logic [1:0] z_op;
        logic       mod_load;
        logic       mul_en;
        logic       mul_a_hi;
        logic       mul_b_hi;
        logic       mul_c2;
        logic [1:0] acc_op;
        logic       mod_step;
        logic       out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### sv/fnvfm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvfm_if
// valid/ready channels for key bytes, routes and the worker count register
// ----------------------------------------------------------------------------

// key byte requests
interface fnvfm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       is_last;

    modport source (output valid, output key_byte, output is_last, input ready);
    modport sink   (input valid, input key_byte, input is_last, output ready);
endinterface

// route results
interface fnvfm_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  worker_index;
    logic [63:0] mixed_hash;

    modport source (output valid, output worker_index, output mixed_hash, input ready);
    modport sink   (input valid, input worker_index, input mixed_hash, output ready);
endinterface

// worker count register writes
interface fnvfm_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] worker_count;

    modport source (output valid, output worker_count, input ready);
    modport sink   (input valid, input worker_count, output ready);
endinterface

### sv/fnvfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvfm_ctrl
// sequencer: byte step, three shift-xor passes, two split multiplies,
// bit-serial modulo and output hand-off
// ----------------------------------------------------------------------------
module fnvfm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_is_last,
    output logic                 o_in_ready,
    input  fnvfm_pkg::t_dp_status i_st,
    output fnvfm_pkg::t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FNV  = 4'd1;
    localparam logic [3:0] S_XS   = 4'd2;
    localparam logic [3:0] S_MUL0 = 4'd3;
    localparam logic [3:0] S_MUL1 = 4'd4;
    localparam logic [3:0] S_MUL2 = 4'd5;
    localparam logic [3:0] S_MUL3 = 4'd6;
    localparam logic [3:0] S_MOD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic [1:0] PASS_LAST = 2'd2;
    localparam logic [fnvfm_pkg::BITCNT_W-1:0] CNT_LAST = '1;

    logic [3:0]                       r_state, n_state;
    logic                             r_last, n_last;
    logic [1:0]                       r_pass, n_pass;
    logic [fnvfm_pkg::BITCNT_W-1:0]   r_cnt, n_cnt;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        n_pass     = r_pass;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_last       = i_is_last;
                    n_state      = S_FNV;
                end
            end
            S_FNV: begin
                o_cmd.fnv_fin = 1'b1;
                n_pass        = 2'd0;
                n_state       = r_last ? S_XS : S_IDLE;
            end
            S_XS: begin
                o_cmd.z_op = (r_pass == 2'd0) ? fnvfm_pkg::Z_FROM_HASH
                                              : fnvfm_pkg::Z_FROM_ACC;
                n_pass = r_pass + 2'd1;
                if (r_pass == PASS_LAST) begin
                    o_cmd.mod_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_MOD;
                end else begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_c2 = (r_pass == PASS_LAST);
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_b_hi = 1'b1;
                o_cmd.mul_c2   = (r_pass == PASS_LAST);
                o_cmd.acc_op   = fnvfm_pkg::ACC_LOAD;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_a_hi = 1'b1;
                o_cmd.mul_c2   = (r_pass == PASS_LAST);
                o_cmd.acc_op   = fnvfm_pkg::ACC_ADD_HI;
                n_state        = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.acc_op = fnvfm_pkg::ACC_ADD_HI;
                n_state      = S_XS;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_pass  <= 2'd0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_pass  <= n_pass;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### sv/fnvfm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvfm_dp
// hash datapath: fnv-1a byte step, shared 32x32 multiplier for fmix64,
// restoring modulo and output register
// ----------------------------------------------------------------------------
module fnvfm_dp #(
    parameter int MAX_WORKERS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fnvfm_pkg::t_dp_cmd          i_cmd,
    output fnvfm_pkg::t_dp_status       o_st,
    input  logic [fnvfm_pkg::BYTE_W-1:0] i_key_byte,
    input  logic                        i_cfg_valid,
    input  logic [fnvfm_pkg::WCNT_W-1:0] i_cfg_worker_count,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fnvfm_pkg::IDX_W-1:0]  o_worker_index,
    output logic [fnvfm_pkg::HASH_W-1:0] o_mixed_hash
);

    localparam int HW = fnvfm_pkg::HASH_W;
    localparam int HL = fnvfm_pkg::HALF_W;
    localparam int WW = fnvfm_pkg::WCNT_W;

    logic [WW-1:0] r_wcnt;
    logic [WW-1:0] n_eff;
    logic [HW-1:0] r_hash, r_xh, r_fnvp;
    logic [HW-1:0] n_xh;
    logic [HW-1:0] r_z, r_acc, r_prod, r_div;
    logic [HW-1:0] n_z, z_src, mul_c;
    logic [HL-1:0] mul_a, mul_b;
    logic [WW-1:0] r_rem;
    logic [WW:0]   rem_sh;
    logic          r_out_valid;
    logic [fnvfm_pkg::IDX_W-1:0] r_out_idx;
    logic [HW-1:0] r_out_hash;

    // worker count register, zero read as one, saturated at the maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= WW'(1);
        end else if (i_cfg_valid) begin
            r_wcnt <= i_cfg_worker_count;
        end
    end

    always_comb begin
        n_eff = r_wcnt;
        if (r_wcnt == '0) begin
            n_eff = WW'(1);
        end
        if (int'(r_wcnt) > MAX_WORKERS) begin
            n_eff = WW'(MAX_WORKERS);
        end
    end

    // fnv-1a: xor byte, then sparse multiply by the prime over the accept and prime add steps
    assign n_xh = r_hash ^ {{(HW - fnvfm_pkg::BYTE_W){1'b0}}, i_key_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= fnvfm_pkg::FNV_BASIS;
        end else if (i_cmd.fnv_fin) begin
            r_hash <= r_fnvp + (r_xh << fnvfm_pkg::FNV_SH_MID)
                             + (r_xh << fnvfm_pkg::FNV_SH_HI);
        end else if (i_cmd.z_op == fnvfm_pkg::Z_FROM_HASH) begin
            r_hash <= fnvfm_pkg::FNV_BASIS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_xh   <= n_xh;
            r_fnvp <= n_xh * {{(HW - 8){1'b0}}, fnvfm_pkg::FNV_PRIME_LO};
        end
    end

    // shift-xor step of the finaliser
    assign z_src = (i_cmd.z_op == fnvfm_pkg::Z_FROM_HASH) ? r_hash : r_acc;
    assign n_z   = z_src ^ (z_src >> fnvfm_pkg::FMIX_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.z_op != fnvfm_pkg::Z_NONE) begin
            r_z <= n_z;
        end
    end

    // shared 32x32 multiplier, low 64 bits built from three partial products
    assign mul_c = i_cmd.mul_c2 ? fnvfm_pkg::FMIX_C2 : fnvfm_pkg::FMIX_C1;
    assign mul_a = i_cmd.mul_a_hi ? r_z[HW-1:HL] : r_z[HL-1:0];
    assign mul_b = i_cmd.mul_b_hi ? mul_c[HW-1:HL] : mul_c[HL-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= HW'(mul_a) * HW'(mul_b);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            fnvfm_pkg::ACC_LOAD: begin
                r_acc <= r_prod;
            end
            fnvfm_pkg::ACC_ADD_HI: begin
                r_acc[HW-1:HL] <= r_acc[HW-1:HL] + r_prod[HL-1:0];
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // restoring modulo, one dividend bit per cycle
    assign rem_sh = {r_rem, r_div[HW-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_load) begin
            r_div <= n_z;
            r_rem <= '0;
        end else if (i_cmd.mod_step) begin
            r_div <= r_div << 1;
            if (rem_sh >= {1'b0, n_eff}) begin
                r_rem <= WW'(rem_sh - {1'b0, n_eff});
            end else begin
                r_rem <= WW'(rem_sh);
            end
        end
    end

    // output register, frees when the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx  <= r_rem[fnvfm_pkg::IDX_W-1:0];
            r_out_hash <= r_z;
        end
    end

    assign o_st.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_worker_index = r_out_idx;
    assign o_mixed_hash   = r_out_hash;

endmodule

### sv/fnv1a_fmix_worker_router_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1a_fmix_worker_router_top
// routes a key to a worker by fnv-1a 64 hashing and the fmix64 finaliser
// ----------------------------------------------------------------------------
// channels: i_key takes one key byte per request (key_byte, is_last);
// o_route gives one request per key (worker_index, mixed_hash); i_cfg writes
// the worker count register, always ready; the user must see that it is
// written only while idle, as the block does not enforce it. a byte not
// marked last passes the accept and the fnv prime add steps. a byte marked
// last is followed by the finaliser: three shift-xors with a constant
// multiply between each pair on a shared 32x32 multiplier, then a
// bit-serial modulo of the 64-bit hash. the next byte can be taken in the
// cycle after the route is loaded. a held route sits in the output
// register; key bytes are still taken while it is held, and the block
// waits only when a new route is ready while the old is unread.
// reset sets the running hash to the fnv offset basis and the worker count
// to one; a count of zero routes as one, counts above MAX_WORKERS saturate.
// ----------------------------------------------------------------------------
module fnv1a_fmix_worker_router_top #(
    parameter int MAX_WORKERS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fnvfm_in_if.sink      i_key,
    fnvfm_out_if.source   o_route,
    fnvfm_cfg_if.sink     i_cfg
);

    fnvfm_pkg::t_dp_cmd    cmd;
    fnvfm_pkg::t_dp_status st;

    assign i_cfg.ready = 1'b1;

    // sequencer
    fnvfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key.valid),
        .i_is_last  (i_key.is_last),
        .o_in_ready (i_key.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // datapath
    fnvfm_dp #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_st               (st),
        .i_key_byte         (i_key.key_byte),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_worker_count (i_cfg.worker_count),
        .o_out_valid        (o_route.valid),
        .i_out_ready        (o_route.ready),
        .o_worker_index     (o_route.worker_index),
        .o_mixed_hash       (o_route.mixed_hash)
    );

    // a route is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> st.out_free)
        else $error("route loaded over an unread route");

    // a new route appears only from a load command
    a_rise_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_route.valid) |-> $past(cmd.out_load))
        else $error("route valid without load");

    // no key byte is taken while the modulo runs
    a_mod_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mod_step |-> !i_key.ready)
        else $error("key byte accepted during modulo");

    // a byte step is always followed by its prime add
    a_fnv_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> cmd.fnv_fin)
        else $error("byte accepted without prime add");

endmodule
